// File: design/emfd_pkg.sv
// ----------------------------------------------------------------------------
// emfd_pkg: shared types and constants for the energy meter frame decoder
// Frame layout constants, status codes and the structs passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package emfd_pkg;

  localparam int FRAME_BYTES = 12;               // bytes per radio frame
  localparam int STORE_DEPTH = FRAME_BYTES - 1;  // bytes kept for decode
  localparam int CNT_W       = $clog2(FRAME_BYTES);

  localparam logic [7:0] HDR_SYNC   = 8'h25;
  localparam logic [7:0] HDR_TYPE_A = 8'h6A;
  localparam logic [7:0] HDR_TYPE_B = 8'h2A;
  localparam logic [7:0] HDR_TYPE_C = 8'h40;
  localparam logic [7:0] FILTER_PAT = 8'hAA;
  localparam logic [7:0] RAW_MASK   = 8'h3F;
  localparam int         PAIR_BIT   = 7;
  localparam int         CONN_BIT   = 6;
  localparam logic [11:0] VOLT_BASE = 12'd1280;  // 128.0 V in tenths

  typedef enum logic [2:0] {
    ST_ACCEPTED   = 3'd0,
    ST_BAD_HEADER = 3'd1,
    ST_PAIRING    = 3'd2,
    ST_CHECKSUM   = 3'd3,
    ST_FILTERED   = 3'd4
  } status_t;

  typedef logic [STORE_DEPTH-1:0][7:0] frame_bytes_t;

  // capture stage -> decode stage
  typedef struct packed {
    logic         done;      // twelfth byte taken this cycle
    logic         sum_zero;  // mod-256 sum of all twelve bytes is zero
    frame_bytes_t bytes;     // bytes 0..10 of the frame
  } frame_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] device_id;
    logic [11:0] voltage_tenths;
    logic [15:0] current_ma;
    logic [12:0] power_w;
    logic [13:0] energy_centi_kwh;
    logic        load_connected;
    logic        pairing;
  } result_t;

endpackage

`default_nettype wire

// File: design/emfd_byte_if.sv
// ----------------------------------------------------------------------------
// emfd_byte_if: byte request channel
// One received frame byte plus the start-of-frame mark, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface emfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, rx_byte, frame_start, input ready);
  modport sink   (input valid, rx_byte, frame_start, output ready);
endinterface

`default_nettype wire

// File: design/emfd_result_if.sv
// ----------------------------------------------------------------------------
// emfd_result_if: decoded frame request channel
// One decoded frame per request, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface emfd_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] device_id;
  logic [11:0] voltage_tenths;
  logic [15:0] current_ma;
  logic [12:0] power_w;
  logic [13:0] energy_centi_kwh;
  logic        load_connected;
  logic        pairing;

  modport source (output valid, status, device_id, voltage_tenths, current_ma,
                  power_w, energy_centi_kwh, load_connected, pairing,
                  input ready);
  modport sink   (input valid, status, device_id, voltage_tenths, current_ma,
                  power_w, energy_centi_kwh, load_connected, pairing,
                  output ready);
endinterface

`default_nettype wire

// File: design/emfd_capture.sv
// ----------------------------------------------------------------------------
// emfd_capture: byte counter, running checksum and frame byte capture
// Flags the twelfth byte of a frame together with the final checksum test.
// ----------------------------------------------------------------------------
`default_nettype none

module emfd_capture
  import emfd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] rx_byte,
  input  wire logic       frame_start,
  output frame_t          frame
);

  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]       byte_sum, byte_sum_next;
  frame_bytes_t     store;

  logic [CNT_W-1:0] cnt_base;
  logic [7:0]       sum_base;
  logic [7:0]       sum_new;
  logic             last;

  assign cnt_base = frame_start ? '0 : byte_count;
  assign sum_base = frame_start ? '0 : byte_sum;
  assign sum_new  = sum_base + rx_byte;
  assign last     = (cnt_base == CNT_W'(FRAME_BYTES - 1));

  always_comb begin
    byte_count_next = byte_count;
    byte_sum_next   = byte_sum;
    if (take) begin
      if (last) begin
        byte_count_next = '0;
        byte_sum_next   = '0;
      end else begin
        byte_count_next = cnt_base + CNT_W'(1);
        byte_sum_next   = sum_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      byte_sum   <= '0;
    end else begin
      byte_count <= byte_count_next;
      byte_sum   <= byte_sum_next;
    end
  end

  // each slot loads when the count points at it; no reset needed
  always_ff @(posedge clk) begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (take && (cnt_base == CNT_W'(i))) begin
        store[i] <= rx_byte;
      end
    end
  end

  assign frame.done     = take && last;
  assign frame.sum_zero = (sum_new == 8'd0);
  assign frame.bytes    = store;

endmodule

`default_nettype wire

// File: design/emfd_decode.sv
// ----------------------------------------------------------------------------
// emfd_decode: field extraction and status priority
// Turns the captured frame bytes into scaled readings and a status code.
// ----------------------------------------------------------------------------
`default_nettype none

module emfd_decode
  import emfd_pkg::*;
(
  input  wire frame_t frame,
  output result_t     res
);

  frame_bytes_t f;
  logic         pair;
  logic         hdr_ok;
  logic [11:0]  volt_raw;

  assign f        = frame.bytes;
  assign pair     = f[4][PAIR_BIT];
  assign hdr_ok   = (f[0] == HDR_SYNC) &&
                    ((f[1] == HDR_TYPE_A) || (f[1] == HDR_TYPE_B) ||
                     (f[1] == HDR_TYPE_C));
  // 5 * byte8 as (byte8 << 2) + byte8
  assign volt_raw = VOLT_BASE + {2'b00, f[8], 2'b00} + {4'b0000, f[8]};

  always_comb begin
    res.device_id = {f[2], f[3]};
    res.pairing   = pair;
    if (pair) begin
      res.voltage_tenths   = '0;
      res.current_ma       = '0;
      res.power_w          = '0;
      res.energy_centi_kwh = '0;
      res.load_connected   = 1'b0;
    end else begin
      res.voltage_tenths   = volt_raw;
      res.current_ma       = {f[6], f[7]};
      // half-watt raw, truncated to watts
      res.power_w          = {f[4][5:0] & RAW_MASK[5:0], f[5][7:1]};
      res.energy_centi_kwh = {f[9][5:0] & RAW_MASK[5:0], f[10]};
      res.load_connected   = f[4][CONN_BIT];
    end

    if (!hdr_ok) begin
      res.status = ST_BAD_HEADER;
    end else if (pair) begin
      res.status = ST_PAIRING;
    end else if (!frame.sum_zero) begin
      res.status = ST_CHECKSUM;
    end else if ((f[6] == FILTER_PAT) && (f[7] == FILTER_PAT)) begin
      res.status = ST_FILTERED;
    end else begin
      res.status = ST_ACCEPTED;
    end
  end

endmodule

`default_nettype wire

// File: design/energy_meter_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// energy_meter_frame_decoder_unit: radio energy meter frame decoder
// Collects twelve-byte frames and emits one decoded reading per frame.
// ----------------------------------------------------------------------------
//
//   channel   | dir | payload                                    | per request
//   ----------+-----+--------------------------------------------+------------
//   byte_in   | in  | rx_byte[7:0], frame_start                  | one byte
//   result    | out | status, device_id, voltage_tenths,         | one frame
//             |     | current_ma, power_w, energy_centi_kwh,     |
//             |     | load_connected, pairing                    |
//
// One byte is taken per cycle while byte_in.ready is high. The twelfth byte
// of a frame is decoded in the cycle it is taken and the reading is stored
// in the result register, so it appears on result in the next cycle. A
// stalled result blocks only byte_in; a new byte is taken in the same cycle
// the waiting result is taken. Synchronous reset clears the byte count,
// checksum and result valid; captured bytes are not cleared.
// frame_start drops any partial frame without a result.
// ----------------------------------------------------------------------------
`default_nettype none

module energy_meter_frame_decoder_unit
  import emfd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  emfd_byte_if.sink      byte_in,
  emfd_result_if.source  result
);

  frame_t  frame;
  result_t decoded;
  result_t res_q;
  logic    out_valid, out_valid_next;
  logic    take;

  // room downstream: result register empty or draining this cycle
  assign byte_in.ready = !out_valid || result.ready;
  assign take          = byte_in.valid && byte_in.ready;

  emfd_capture u_capture (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .rx_byte     (byte_in.rx_byte),
    .frame_start (byte_in.frame_start),
    .frame       (frame)
  );

  emfd_decode u_decode (
    .frame (frame),
    .res   (decoded)
  );

  always_comb begin
    out_valid_next = out_valid;
    if (frame.done) begin
      out_valid_next = 1'b1;
    end else if (result.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.done) begin
      res_q <= decoded;
    end
  end

  assign result.valid            = out_valid;
  assign result.status           = res_q.status;
  assign result.device_id        = res_q.device_id;
  assign result.voltage_tenths   = res_q.voltage_tenths;
  assign result.current_ma       = res_q.current_ma;
  assign result.power_w          = res_q.power_w;
  assign result.energy_centi_kwh = res_q.energy_centi_kwh;
  assign result.load_connected   = res_q.load_connected;
  assign result.pairing          = res_q.pairing;

  // a completed frame always shows up on the next cycle
  a_done_to_valid: assert property (@(posedge clk) disable iff (rst)
    frame.done |=> result.valid)
    else $error("completed frame not presented");

  // a pending result is never overwritten by a new frame
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |-> !frame.done)
    else $error("pending result overwritten");

  // pairing frames carry no readings and only header or pairing status
  a_pair_fields: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.pairing) |->
      (result.voltage_tenths == 12'd0 && result.current_ma == 16'd0 &&
       (result.status == ST_BAD_HEADER || result.status == ST_PAIRING)))
    else $error("pairing result inconsistent");

  // normal readings keep the voltage offset
  a_volt_floor: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.pairing) |-> (result.voltage_tenths >= VOLT_BASE))
    else $error("voltage below base");

endmodule

`default_nettype wire
